FILE: hw/rtl/aesfk_pkg.sv
// Shared types, constants and round functions for the fixed-key AES block.
// No dependencies.
package aesfk_pkg;

    localparam int ROUNDS = 10;
    localparam int STAGES = ROUNDS + 1;

    localparam logic [63:0] KEY_HIGH_RESET = 64'h0011223344556677;
    localparam logic [63:0] KEY_LOW_RESET  = 64'h8899aabbccddeeff;

    typedef enum logic {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } cfg_index_t;

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } op_t;

    typedef logic [127:0] state_t;

    typedef struct packed {
        logic   valid;
        op_t    op;
        state_t data;
    } beat_t;

    localparam logic [7:0] FWD_SUB [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SUB [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte k of the state sits at bits [127-8k -: 8]
    function automatic logic [7:0] get_byte(input state_t s, input int k);
        get_byte = s[127 - 8 * k -: 8];
    endfunction

    function automatic state_t sub_bytes(input state_t s, input op_t op);
        state_t t;
        for (int k = 0; k < 16; k++) begin
            if (op == OP_ENCRYPT) begin
                t[127 - 8 * k -: 8] = FWD_SUB[get_byte(s, k)];
            end else begin
                t[127 - 8 * k -: 8] = INV_SUB[get_byte(s, k)];
            end
        end
        sub_bytes = t;
    endfunction

    function automatic state_t shift_rows(input state_t s, input op_t op);
        state_t t;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (op == OP_ENCRYPT) begin
                    t[127 - 8 * (c * 4 + r) -: 8] = get_byte(s, ((c + r) % 4) * 4 + r);
                end else begin
                    t[127 - 8 * (((c + r) % 4) * 4 + r) -: 8] = get_byte(s, c * 4 + r);
                end
            end
        end
        shift_rows = t;
    endfunction

    function automatic state_t mix_columns(input state_t s, input op_t op);
        state_t t;
        logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, u, v;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, c * 4);
            a1 = get_byte(s, c * 4 + 1);
            a2 = get_byte(s, c * 4 + 2);
            a3 = get_byte(s, c * 4 + 3);
            if (op == OP_DECRYPT) begin
                // fold inverse mix into the forward one
                u = xtime(xtime(a0 ^ a2));
                v = xtime(xtime(a1 ^ a3));
                a0 = a0 ^ u;
                a1 = a1 ^ v;
                a2 = a2 ^ u;
                a3 = a3 ^ v;
            end
            x0 = xtime(a0);
            x1 = xtime(a1);
            x2 = xtime(a2);
            x3 = xtime(a3);
            t[127 - 8 * (c * 4) -: 8]     = x0 ^ x1 ^ a1 ^ a2 ^ a3;
            t[127 - 8 * (c * 4 + 1) -: 8] = a0 ^ x1 ^ x2 ^ a2 ^ a3;
            t[127 - 8 * (c * 4 + 2) -: 8] = a0 ^ a1 ^ x2 ^ x3 ^ a3;
            t[127 - 8 * (c * 4 + 3) -: 8] = x0 ^ a0 ^ a1 ^ a2 ^ x3;
        end
        mix_columns = t;
    endfunction

endpackage

FILE: hw/rtl/aes_fixed_key_block_cipher.sv
// Top level of the fixed-key AES block: key registers and the round chain.
// Depends on aesfk_pkg and aesfk_round_cell.
//
// Each block passes through a key-add cell followed by one cell per round,
// each cell a pipeline register. The chain advances whenever the output
// stage is empty or taken, so throughput is one block per cycle unless a
// valid output is stalled, which also raises in_stall upstream. The same key
// is added at every point; rewrite it only while the chain is empty.
module aes_fixed_key_block_cipher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] result_high,
    output logic [63:0] result_low
);
    import aesfk_pkg::*;

    logic [63:0] key_high_reg, key_low_reg;
    logic        advance;
    beat_t       chain [STAGES + 1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_high_reg <= KEY_HIGH_RESET;
            key_low_reg  <= KEY_LOW_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index_t'(cfg_index))
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                default:      key_high_reg <= key_high_reg;
            endcase
        end
    end

    assign advance  = !(chain[STAGES].valid && out_stall);
    assign in_stall = !advance;

    assign chain[0] = '{valid: in_valid, op: op_t'(operation),
                        data: {block_high, block_low}};

    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        aesfk_round_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .is_first (g == 0),
            .is_last  (g == STAGES - 1),
            .key      ({key_high_reg, key_low_reg}),
            .beat_in  (chain[g]),
            .beat_out (chain[g + 1])
        );
    end

    assign out_valid   = chain[STAGES].valid;
    assign result_high = chain[STAGES].data[127:64];
    assign result_low  = chain[STAGES].data[63:0];

endmodule

FILE: hw/rtl/aesfk_round_cell.sv
// One round cell of the cipher chain: a round (key add alone if first, no column mix if last) and a stage register.
// Depends on aesfk_pkg.
module aesfk_round_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            is_first,
    input  logic            is_last,
    input  aesfk_pkg::state_t key,
    input  aesfk_pkg::beat_t  beat_in,
    output aesfk_pkg::beat_t  beat_out
);
    import aesfk_pkg::*;

    beat_t  beat_reg;
    beat_t  beat_next;
    state_t enc_s, dec_s, round_s;

    always_comb
    begin
        enc_s = shift_rows(sub_bytes(beat_in.data, OP_ENCRYPT), OP_ENCRYPT);
        if (!is_last) begin
            enc_s = mix_columns(enc_s, OP_ENCRYPT);
        end
        enc_s = enc_s ^ key;
        dec_s = sub_bytes(shift_rows(beat_in.data, OP_DECRYPT), OP_DECRYPT) ^ key;
        if (!is_last) begin
            dec_s = mix_columns(dec_s, OP_DECRYPT);
        end
        if (is_first) begin
            round_s = beat_in.data ^ key;
        end else if (beat_in.op == OP_ENCRYPT) begin
            round_s = enc_s;
        end else begin
            round_s = dec_s;
        end
        beat_next = beat_reg;
        if (advance) begin
            beat_next = '{valid: beat_in.valid, op: beat_in.op, data: round_s};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            beat_reg <= '0;
        end else begin
            beat_reg <= beat_next;
        end
    end

    assign beat_out = beat_reg;

endmodule

FILE: tb/sv/tb_aes_fixed_key_block_cipher.sv
// Testbench for aes_fixed_key_block_cipher: drives encrypt and decrypt beats under
// random idling and stalls, predicts each result with its own round model.
// Depends on aesfk_pkg and the RTL of aes_fixed_key_block_cipher.
`timescale 1ns / 100ps

module tb_aes_fixed_key_block_cipher;
    import aesfk_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [0:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        operation;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] result_high;
    logic [63:0] result_low;

    logic [63:0]  key_hi_model;
    logic [63:0]  key_lo_model;
    logic [127:0] expected_blocks[$];
    int           error_count;
    int           hold_off_cycles;
    bit           stall_enable;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    aes_fixed_key_block_cipher DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
        .block_high(block_high), .block_low(block_low),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_high(result_high), .result_low(result_low)
    );

    always #10 clk = ~clk;

    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc = acc ^ a;
            a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
        end
        return acc;
    endfunction

    function automatic logic [127:0] cipher_block(input op_t op, input logic [127:0] blk,
                                                  input logic [127:0] key);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] inv_box [256];
        logic [7:0] coef [4];
        logic [127:0] res;
        for (int i = 0; i < 256; i++)
            inv_box[SBOX[i]] = i[7:0];
        for (int k = 0; k < 16; k++)
            s[k] = blk[127 - 8 * k -: 8] ^ key[127 - 8 * k -: 8];
        for (int rnd = 0; rnd < ROUNDS; rnd++)
        begin
            if (op == OP_ENCRYPT)
            begin
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                        t[c * 4 + r] = SBOX[s[((c + r) % 4) * 4 + r]];
                coef = '{8'd2, 8'd3, 8'd1, 8'd1};
            end
            else
            begin
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                        t[((c + r) % 4) * 4 + r] = inv_box[s[c * 4 + r]];
                coef = '{8'd14, 8'd11, 8'd13, 8'd9};
            end
            for (int k = 0; k < 16; k++)
                t[k] = t[k] ^ key[127 - 8 * k -: 8];
            if (rnd < ROUNDS - 1)
            begin
                if (op == OP_ENCRYPT)
                    for (int k = 0; k < 16; k++)
                        t[k] = t[k] ^ key[127 - 8 * k -: 8];
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                    begin
                        s[c * 4 + r] = 8'h00;
                        for (int j = 0; j < 4; j++)
                            s[c * 4 + r] = s[c * 4 + r]
                                ^ gf_times(t[c * 4 + j], coef[(j - r + 4) % 4]);
                    end
                if (op == OP_ENCRYPT)
                    for (int k = 0; k < 16; k++)
                        s[k] = s[k] ^ key[127 - 8 * k -: 8];
            end
            else
                s = t;
        end
        for (int k = 0; k < 16; k++)
            res[127 - 8 * k -: 8] = s[k];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
        error_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        logic [127:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_blocks.size() == 0)
                report_mismatch("unexpected beat", result_high, 64'h0);
            else
            begin
                want = expected_blocks.pop_front();
                if (result_high !== want[127:64])
                    report_mismatch("result_high", result_high, want[127:64]);
                if (result_low !== want[63:0])
                    report_mismatch("result_low", result_low, want[63:0]);
            end
        end
    end

    // receiver stall pattern, with an optional long hold-off
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else if (stall_enable)
            out_stall <= ($urandom_range(0, 3) == 0);
        else
            out_stall <= 1'b0;
    end

    task automatic send_block(input op_t op, input logic [63:0] hi, input logic [63:0] lo);
        operation  <= op;
        block_high <= hi;
        block_low  <= lo;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_blocks.push_back(cipher_block(op, {hi, lo}, {key_hi_model, key_lo_model}));
    endtask

    task automatic idle_sender(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_pipe();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_blocks.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (ROUNDS + 4) @(posedge clk);
    endtask

    task automatic write_key(input cfg_index_t idx, input logic [63:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_KEY_HIGH)
            key_hi_model = value;
        else
            key_lo_model = value;
    endtask

    task automatic send_random_burst(input int count, input int max_gap);
        int burst;
        while (count > 0)
        begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && count > 0; i++, count--)
                send_block(op_t'($urandom_range(0, 1)), {$urandom, $urandom},
                           {$urandom, $urandom});
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, max_gap));
        end
    endtask

    task automatic test_reset_key_directed();
        send_block(OP_ENCRYPT, 64'h0, 64'h0);
        send_block(OP_DECRYPT, 64'h0, 64'h0);
        send_block(OP_ENCRYPT, '1, '1);
        send_block(OP_DECRYPT, '1, '1);
        send_block(OP_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001);
        send_block(OP_DECRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
        send_block(OP_ENCRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        send_block(OP_DECRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        drain_pipe();
    endtask

    task automatic test_key_extremes();
        write_key(REG_KEY_HIGH, 64'h0);
        write_key(REG_KEY_LOW, 64'h0);
        send_block(OP_ENCRYPT, 64'h0, 64'h0);
        send_block(OP_DECRYPT, '1, 64'h0);
        drain_pipe();
        write_key(REG_KEY_HIGH, '1);
        write_key(REG_KEY_LOW, '1);
        send_block(OP_ENCRYPT, '1, '1);
        send_block(OP_DECRYPT, 64'h0, '1);
        drain_pipe();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++)
        begin
            write_key(REG_KEY_HIGH, {$urandom, $urandom});
            write_key(REG_KEY_LOW, {$urandom, $urandom});
            stall_enable = (phase % 3 != 2);
            send_random_burst(250, (phase == 1) ? 12 : 4);
            drain_pipe();
        end
        stall_enable = 1'b1;
    endtask

    task automatic test_backpressure_fill();
        hold_off_cycles <= 60;
        @(posedge clk);
        send_random_burst(200, 1);
        drain_pipe();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_KEY_HIGH;
        cfg_data = '0;
        in_valid = 1'b0;
        operation = OP_ENCRYPT;
        block_high = '0;
        block_low = '0;
        out_stall = 1'b0;
        hold_off_cycles = 0;
        stall_enable = 1'b1;
        error_count = 0;
        key_hi_model = KEY_HIGH_RESET;
        key_lo_model = KEY_LOW_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_key_directed();
        test_key_extremes();
        test_random_traffic();
        test_backpressure_fill();
        if (error_count == 0 && expected_blocks.size() == 0)
            $display("aes_fixed_key_block_cipher verification clean");
        else
        begin
            if (expected_blocks.size() != 0)
                $display("%0d expected results never arrived", expected_blocks.size());
            $display("aes_fixed_key_block_cipher verification failed");
        end
        $finish;
    end

    initial
    begin
        #20000000;
        $display("aes_fixed_key_block_cipher verification failed");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/aesfk_pkg.sv
hw/rtl/aesfk_round_cell.sv
hw/rtl/aes_fixed_key_block_cipher.sv
tb/sv/tb_aes_fixed_key_block_cipher.sv
